[src/tra_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tra_pkg
// Shared types and constants for the ternary ring automaton.
// ----------------------------------------------------------------------------
package tra_pkg;

    localparam int CELL_W      = 2;
    localparam int RULE_W      = 43;
    localparam int RULE_DIGITS = 27;
    localparam int DIGIT_W     = 5;
    localparam int LAST_DIGIT  = 26;
    localparam int WORK_W      = 48;
    localparam int CHUNK_W     = 8;
    localparam int CHUNKS      = WORK_W / CHUNK_W;
    localparam int CHUNK_CNT_W = 3;
    localparam int RADIX       = 3;
    localparam int IDX_PORT_W  = 6;
    localparam int CMD_W       = 2;

    localparam logic [RULE_W-1:0] RULE_MOD = 43'd7625597484987;

    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STEP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEED = 2'd2;

    localparam logic [CELL_W-1:0] VAL_MAX = 2'd2;

    typedef logic [RULE_DIGITS-1:0][CELL_W-1:0] rule_digits_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOAD,
        OP_SEED,
        OP_STEP,
        OP_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [CELL_W-1:0] value;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        RS_IDLE,
        RS_REDUCE,
        RS_DIV
    } rule_state_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } ring_state_t;

endpackage

[src/ternary_ring_automaton.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ternary_ring_automaton
// Three-color radius-1 cellular automaton on a ring of CELLS cells.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) takes one item per command: load writes
// one cell (indexes at or past CELLS are dropped), seed clears the ring and
// sets the middle cell, step computes a new generation.
// Values of 3 are taken as 2. Load and seed give no output items.
// After a step the output channel (out_valid / out_stall) gives CELLS items,
// cell 0 first, last set on the final one. The first item shows in the cycle
// after the step is taken, then one item per cycle while out_stall is low.
// The ring rotates one position per delivered item, and in_stall is high
// until the last item goes. A stalled receiver simply freezes the ring
// with the item held.
// Writing rule_number starts the digit unit: a reduce state, then 27 digits
// one after another; input items are held off meanwhile.
// Reset clears all cells and sets rule 0; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ternary_ring_automaton #(
    parameter int CELLS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              rule_wr_en,
    input  logic [tra_pkg::RULE_W-1:0]        rule_number,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [tra_pkg::CMD_W-1:0]         cmd,
    input  logic [tra_pkg::IDX_PORT_W-1:0]    cell_index,
    input  logic [tra_pkg::CELL_W-1:0]        cell_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tra_pkg::IDX_PORT_W-1:0]    out_index,
    output logic [tra_pkg::CELL_W-1:0]        out_value,
    output logic                              last
);

    localparam int IDX_W  = $clog2(CELLS);
    localparam int CENTER = CELLS / 2;

    tra_pkg::ring_state_t          state_reg;
    tra_pkg::ring_state_t          state_next;
    logic [IDX_W-1:0]              cnt_reg;
    logic [IDX_W-1:0]              cnt_next;
    logic                          rule_busy;
    tra_pkg::rule_digits_t         digits;
    tra_pkg::cell_ctrl_t           ctrl;
    logic                          in_accept;
    logic                          out_accept;
    logic                          cnt_last;
    logic                          load_ok;
    logic [CELLS-1:0]              sel;
    logic [tra_pkg::CELL_W-1:0]    ring [CELLS];

    tra_rule u_rule (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rule_wr_en),
        .wr_data (rule_number),
        .busy    (rule_busy),
        .digits  (digits)
    );

    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid && !out_stall;
    assign cnt_last   = (cnt_reg == IDX_W'(CELLS - 1));
    assign load_ok    = ({1'b0, cell_index} < 7'(CELLS));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tra_pkg::ST_IDLE:
            begin
                if (in_accept && cmd == tra_pkg::CMD_STEP)
                begin
                    state_next = tra_pkg::ST_EMIT;
                end
            end
            tra_pkg::ST_EMIT:
            begin
                if (out_accept && cnt_last)
                begin
                    state_next = tra_pkg::ST_IDLE;
                end
            end
            default: state_next = tra_pkg::ST_IDLE;
        endcase
    end

    // outputs and cell control
    always_comb
    begin
        in_stall   = (state_reg != tra_pkg::ST_IDLE) || rule_busy;
        out_valid  = (state_reg == tra_pkg::ST_EMIT);
        ctrl.op    = tra_pkg::OP_HOLD;
        ctrl.value = (cell_value > tra_pkg::VAL_MAX) ? tra_pkg::VAL_MAX : cell_value;
        if (in_accept)
        begin
            unique case (cmd)
                tra_pkg::CMD_LOAD: ctrl.op = load_ok ? tra_pkg::OP_LOAD : tra_pkg::OP_HOLD;
                tra_pkg::CMD_STEP: ctrl.op = tra_pkg::OP_STEP;
                tra_pkg::CMD_SEED: ctrl.op = tra_pkg::OP_SEED;
                default:           ctrl.op = tra_pkg::OP_HOLD;
            endcase
        end
        else if (out_accept)
        begin
            ctrl.op = tra_pkg::OP_SHIFT;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (out_accept)
        begin
            cnt_next = cnt_last ? '0 : cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tra_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        assign sel[i] = (ctrl.op == tra_pkg::OP_SEED) ? (i == CENTER)
                                                      : (cell_index == 6'(i));

        tra_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (ctrl),
            .sel    (sel[i]),
            .digits (digits),
            .left   (ring[(i + CELLS - 1) % CELLS]),
            .right  (ring[(i + 1) % CELLS]),
            .value  (ring[i])
        );
    end

    // cell 0 always holds the cell being emitted
    assign out_value = ring[0];
    assign out_index = tra_pkg::IDX_PORT_W'(cnt_reg);
    assign last      = cnt_last;

endmodule

[src/tra_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tra_cell
// One ring cell: holds a three-valued state, applies the rule from its
// neighborhood, and passes its value to the left neighbor while emitting.
// ----------------------------------------------------------------------------
module tra_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tra_pkg::cell_ctrl_t           ctrl,
    input  logic                          sel,
    input  tra_pkg::rule_digits_t         digits,
    input  logic [tra_pkg::CELL_W-1:0]    left,
    input  logic [tra_pkg::CELL_W-1:0]    right,
    output logic [tra_pkg::CELL_W-1:0]    value
);

    logic [tra_pkg::CELL_W-1:0]  value_reg;
    logic [tra_pkg::CELL_W-1:0]  value_next;
    logic [tra_pkg::DIGIT_W-1:0] nb;
    logic [tra_pkg::CELL_W-1:0]  rule_out;

    // neighborhood code 9*left + 3*self + right
    assign nb = ({3'b0, left} * 5'd9) + ({3'b0, value_reg} * 5'(tra_pkg::RADIX))
              + {3'b0, right};

    always_comb
    begin
        if (nb < 5'(tra_pkg::RULE_DIGITS))
        begin
            rule_out = digits[nb];
        end
        else
        begin
            rule_out = '0;
        end
    end

    always_comb
    begin
        value_next = value_reg;
        unique case (ctrl.op)
            tra_pkg::OP_LOAD:  value_next = sel ? ctrl.value : value_reg;
            tra_pkg::OP_SEED:  value_next = sel ? ctrl.value : '0;
            tra_pkg::OP_STEP:  value_next = rule_out;
            tra_pkg::OP_SHIFT: value_next = right;
            default:           value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

[src/tra_rule.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tra_rule
// Rule digit unit: reduces a written rule number modulo 3^27 and peels off
// its 27 base-3 digits by repeated division by three, 8 bits per cycle.
// ----------------------------------------------------------------------------
module tra_rule (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [tra_pkg::RULE_W-1:0]    wr_data,
    output logic                          busy,
    output tra_pkg::rule_digits_t         digits
);

    tra_pkg::rule_state_t                state_reg;
    tra_pkg::rule_state_t                state_next;
    logic [tra_pkg::WORK_W-1:0]          work_reg;
    logic [tra_pkg::WORK_W-1:0]          work_next;
    logic [tra_pkg::CELL_W-1:0]          rem_reg;
    logic [tra_pkg::CELL_W-1:0]          rem_next;
    logic [tra_pkg::CHUNK_CNT_W-1:0]     chunk_reg;
    logic [tra_pkg::CHUNK_CNT_W-1:0]     chunk_next;
    logic [tra_pkg::DIGIT_W-1:0]         digit_reg;
    logic [tra_pkg::DIGIT_W-1:0]         digit_next;
    tra_pkg::rule_digits_t               digits_reg;
    tra_pkg::rule_digits_t               digits_next;
    logic [tra_pkg::CHUNK_W-1:0]         quot;
    logic [tra_pkg::CELL_W-1:0]          rem_out;
    logic                                last_chunk;

    // long division of one byte by three, remainder carried in and out
    function automatic logic [tra_pkg::CHUNK_W+tra_pkg::CELL_W-1:0] div3_chunk(
        input logic [tra_pkg::CELL_W-1:0]  rem_in,
        input logic [tra_pkg::CHUNK_W-1:0] bits
    );
        logic [tra_pkg::CELL_W-1:0]  r;
        logic [2:0]                  t;
        logic [tra_pkg::CHUNK_W-1:0] q;
        r = rem_in;
        q = '0;
        for (int k = tra_pkg::CHUNK_W - 1; k >= 0; k--)
        begin
            t = {r, bits[k]};
            if (t >= 3'(tra_pkg::RADIX))
            begin
                q[k] = 1'b1;
                t    = t - 3'(tra_pkg::RADIX);
            end
            r = t[tra_pkg::CELL_W-1:0];
        end
        return {q, r};
    endfunction

    assign {quot, rem_out} = div3_chunk(rem_reg,
                                        work_reg[tra_pkg::WORK_W-1 -: tra_pkg::CHUNK_W]);
    assign last_chunk = (chunk_reg == tra_pkg::CHUNK_CNT_W'(tra_pkg::CHUNKS - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        if (wr_en)
        begin
            state_next = tra_pkg::RS_REDUCE;
        end
        else
        begin
            unique case (state_reg)
                tra_pkg::RS_IDLE:   state_next = tra_pkg::RS_IDLE;
                tra_pkg::RS_REDUCE: state_next = tra_pkg::RS_DIV;
                tra_pkg::RS_DIV:
                begin
                    if (last_chunk && digit_reg == tra_pkg::DIGIT_W'(tra_pkg::LAST_DIGIT))
                    begin
                        state_next = tra_pkg::RS_IDLE;
                    end
                end
                default:            state_next = tra_pkg::RS_IDLE;
            endcase
        end
    end

    // outputs
    always_comb
    begin
        busy = (state_reg != tra_pkg::RS_IDLE);
    end

    // datapath
    always_comb
    begin
        work_next   = work_reg;
        rem_next    = rem_reg;
        chunk_next  = chunk_reg;
        digit_next  = digit_reg;
        digits_next = digits_reg;
        if (wr_en)
        begin
            work_next = tra_pkg::WORK_W'(wr_data);
        end
        else
        begin
            unique case (state_reg)
                tra_pkg::RS_REDUCE:
                begin
                    // value is below twice the modulus, one subtract is enough
                    if (work_reg[tra_pkg::RULE_W-1:0] >= tra_pkg::RULE_MOD)
                    begin
                        work_next = work_reg - tra_pkg::WORK_W'(tra_pkg::RULE_MOD);
                    end
                    rem_next   = '0;
                    chunk_next = '0;
                    digit_next = '0;
                end
                tra_pkg::RS_DIV:
                begin
                    work_next = {work_reg[tra_pkg::WORK_W-tra_pkg::CHUNK_W-1:0], quot};
                    if (last_chunk)
                    begin
                        // new digit enters at the top, first digit ends at index 0
                        digits_next = {rem_out, digits_reg[tra_pkg::RULE_DIGITS-1:1]};
                        rem_next    = '0;
                        chunk_next  = '0;
                        digit_next  = digit_reg + 1'b1;
                    end
                    else
                    begin
                        rem_next   = rem_out;
                        chunk_next = chunk_reg + 1'b1;
                    end
                end
                default:
                begin
                    work_next = work_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tra_pkg::RS_IDLE;
            chunk_reg  <= '0;
            digit_reg  <= '0;
            digits_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            chunk_reg  <= chunk_next;
            digit_reg  <= digit_next;
            digits_reg <= digits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

    assign digits = digits_reg;

endmodule

[src/tra_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tra_chk
// Port-level checks for the ternary ring automaton, bound to the top level.
// ----------------------------------------------------------------------------
module tra_chk #(
    parameter int CELLS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_stall,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [tra_pkg::IDX_PORT_W-1:0]    out_index,
    input  logic [tra_pkg::CELL_W-1:0]        out_value,
    input  logic                              last
);

    // a held item keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_index) && $stable(out_value)
                                   && $stable(last))
        else $error("held output item changed");

    // items of a generation come in index order without gaps
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=>
            out_valid && (out_index == $past(out_index) + 6'd1))
        else $error("output index not consecutive");

    // the generation ends after the last item
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last |=> !out_valid)
        else $error("output continued past last item");

    // last marks exactly the final cell
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (out_index == 6'(CELLS - 1))))
        else $error("last flag on wrong cell");

    // no new item is taken while a generation is being emitted
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open during emission");

endmodule

bind ternary_ring_automaton tra_chk #(.CELLS(CELLS)) u_tra_chk (.*);

[sim/tb_ternary_ring_automaton.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ternary_ring_automaton
// Self-checking bench for the three-color ring automaton. A tracker class
// keeps its own copy of the ring and rule digits, works out every generation
// a step item causes, and compares the emitted cells one by one. Stimulus is
// a short directed run followed by seeded or loaded rings stepped several
// generations under a series of rules, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_ternary_ring_automaton;

    localparam int RING_CELLS = 64;
    localparam int SEED_POS   = RING_CELLS / 2;
    localparam int IDLE_LIMIT = 2000;
    localparam int PHASE_CMDS = 52;
    localparam logic [tra_pkg::CMD_W-1:0] CMD_NONE = 2'd3;
    localparam logic [tra_pkg::RULE_W-1:0] RULE_ALL_ONES = {tra_pkg::RULE_W{1'b1}};

    typedef struct {
        logic [tra_pkg::IDX_PORT_W-1:0] index;
        logic [tra_pkg::CELL_W-1:0]     value;
        logic                           last;
    } cell_out_t;

    class ring_tracker;
        logic [tra_pkg::CELL_W-1:0] ring [RING_CELLS];
        logic [tra_pkg::CELL_W-1:0] digits [tra_pkg::RULE_DIGITS];
        cell_out_t                  gen_q [$];
        int                         mismatches;

        function new();
            foreach (ring[i]) ring[i] = '0;
            foreach (digits[k]) digits[k] = '0;
            mismatches = 0;
        endfunction

        function void load_rule(logic [tra_pkg::RULE_W-1:0] rule);
            longint unsigned n;
            n = rule % tra_pkg::RULE_MOD;
            for (int k = 0; k < tra_pkg::RULE_DIGITS; k++)
            begin
                digits[k] = tra_pkg::CELL_W'(n % tra_pkg::RADIX);
                n = n / tra_pkg::RADIX;
            end
        endfunction

        function void take_command(logic [tra_pkg::CMD_W-1:0] c,
                                   logic [tra_pkg::IDX_PORT_W-1:0] idx,
                                   logic [tra_pkg::CELL_W-1:0] v);
            logic [tra_pkg::CELL_W-1:0] val;
            logic [tra_pkg::CELL_W-1:0] nxt [RING_CELLS];
            int                         nb;
            cell_out_t                  item;
            val = (v > tra_pkg::VAL_MAX) ? tra_pkg::VAL_MAX : v;
            case (c)
                tra_pkg::CMD_LOAD:
                begin
                    if (idx < RING_CELLS)
                        ring[idx] = val;
                end
                tra_pkg::CMD_SEED:
                begin
                    foreach (ring[i]) ring[i] = '0;
                    ring[SEED_POS] = val;
                end
                tra_pkg::CMD_STEP:
                begin
                    for (int i = 0; i < RING_CELLS; i++)
                    begin
                        nb = 9 * int'(ring[(i + RING_CELLS - 1) % RING_CELLS])
                           + 3 * int'(ring[i])
                           + int'(ring[(i + 1) % RING_CELLS]);
                        nxt[i] = (nb < tra_pkg::RULE_DIGITS) ? digits[nb] : '0;
                    end
                    for (int i = 0; i < RING_CELLS; i++)
                    begin
                        ring[i]    = nxt[i];
                        item.index = tra_pkg::IDX_PORT_W'(i);
                        item.value = nxt[i];
                        item.last  = (i == RING_CELLS - 1);
                        gen_q      = {gen_q, item};
                    end
                end
                default: ;
            endcase
        endfunction

        function void match_cell(logic [tra_pkg::IDX_PORT_W-1:0] idx,
                                 logic [tra_pkg::CELL_W-1:0] v,
                                 logic lst);
            cell_out_t want;
            if (gen_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%0t: cell item with none pending: index %0d value %0d last %0d",
                             $realtime, idx, v, lst);
                mismatches++;
                return;
            end
            want = gen_q.pop_front();
            if (idx !== want.index || v !== want.value || lst !== want.last)
            begin
                if (mismatches < 10)
                    $display("%0t: cell mismatch: index %0d/%0d value %0d/%0d last %0d/%0d",
                             $realtime, want.index, idx, want.value, v, want.last, lst);
                mismatches++;
            end
        endfunction

        function int waiting();
            return gen_q.size();
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           rule_wr_en = 1'b0;
    logic [tra_pkg::RULE_W-1:0]     rule_number = '0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [tra_pkg::CMD_W-1:0]      cmd = tra_pkg::CMD_LOAD;
    logic [tra_pkg::IDX_PORT_W-1:0] cell_index = '0;
    logic [tra_pkg::CELL_W-1:0]     cell_value = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [tra_pkg::IDX_PORT_W-1:0] out_index;
    logic [tra_pkg::CELL_W-1:0]     out_value;
    logic                           last;

    ring_tracker tracker = new();
    logic        idle_on = 1'b1;
    int          cmd_count = 0;
    int          stall_left = 0;
    int          quiet_cycles = 0;

    ternary_ring_automaton #(
        .CELLS(RING_CELLS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .rule_wr_en (rule_wr_en),
        .rule_number(rule_number),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .cell_index (cell_index),
        .cell_value (cell_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_index  (out_index),
        .out_value  (out_value),
        .last       (last)
    );

    always #10 clk = ~clk;

    // receive side: check accepted cells, then pick the stall for the next cycle
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            tracker.match_cell(out_index, out_value, last);
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 3);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || rule_wr_en)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("ternary_ring_automaton test failed");
            $finish;
        end
    end

    task automatic send_item(logic [tra_pkg::CMD_W-1:0] c,
                             logic [tra_pkg::IDX_PORT_W-1:0] idx,
                             logic [tra_pkg::CELL_W-1:0] v);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        cell_index <= idx;
        cell_value <= v;
        do @(posedge clk); while (in_stall);
        tracker.take_command(c, idx, v);
        if (c != CMD_NONE)
            cmd_count++;
    endtask

    task automatic drain_cells();
        in_valid <= 1'b0;
        while (tracker.waiting() != 0) @(posedge clk);
    endtask

    task automatic write_rule(logic [tra_pkg::RULE_W-1:0] rule);
        drain_cells();
        // a load or seed may still be settling
        repeat (4) @(posedge clk);
        rule_wr_en  <= 1'b1;
        rule_number <= rule;
        @(posedge clk);
        rule_wr_en <= 1'b0;
        tracker.load_rule(rule);
    endtask

    function automatic logic [tra_pkg::RULE_W-1:0] rand_rule();
        return {11'($urandom_range(0, 2047)), 32'($urandom)};
    endfunction

    // mostly seeded or loaded rings run for a few generations, some loose items
    task automatic run_generations(int target);
        int pick;
        while (cmd_count < target)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                if ($urandom_range(0, 1))
                    send_item(tra_pkg::CMD_SEED, 6'($urandom), 2'($urandom));
                else
                    repeat ($urandom_range(1, 6))
                        send_item(tra_pkg::CMD_LOAD, 6'($urandom), 2'($urandom));
                repeat ($urandom_range(1, 5))
                    send_item(tra_pkg::CMD_STEP, 6'($urandom), 2'($urandom));
            end
            else if (pick < 9)
                send_item(2'($urandom_range(0, 2)), 6'($urandom), 2'($urandom));
            else
                send_item(CMD_NONE, 6'($urandom), 2'($urandom));
        end
    endtask

    initial
    begin
        logic [tra_pkg::RULE_W-1:0] rules [7];
        rules[0] = RULE_ALL_ONES;
        rules[1] = tra_pkg::RULE_MOD - 1;
        rules[2] = tra_pkg::RULE_MOD;
        rules[3] = '0;
        rules[4] = rand_rule();
        rules[5] = rand_rule();
        rules[6] = rand_rule();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        write_rule(rand_rule());
        send_item(tra_pkg::CMD_SEED, 6'd0, 2'd1);
        repeat (3) send_item(tra_pkg::CMD_STEP, 6'd0, 2'd0);
        // value three taken as two
        send_item(tra_pkg::CMD_SEED, 6'd63, 2'd3);
        send_item(tra_pkg::CMD_STEP, 6'd63, 2'd3);
        // both ends of the ring, wraparound neighbors
        send_item(tra_pkg::CMD_LOAD, 6'd0, 2'd2);
        send_item(tra_pkg::CMD_LOAD, 6'd63, 2'd1);
        send_item(tra_pkg::CMD_LOAD, 6'd63, 2'd3);
        send_item(tra_pkg::CMD_STEP, 6'd0, 2'd0);
        send_item(tra_pkg::CMD_LOAD, 6'd1, 2'd0);
        send_item(CMD_NONE, 6'd63, 2'd3);
        send_item(tra_pkg::CMD_STEP, 6'd0, 2'd0);
        // all-zero ring uses the lowest digit
        send_item(tra_pkg::CMD_SEED, 6'd0, 2'd0);
        send_item(tra_pkg::CMD_STEP, 6'd0, 2'd0);
        send_item(tra_pkg::CMD_LOAD, 6'd62, 2'd2);
        send_item(tra_pkg::CMD_LOAD, 6'd31, 2'd1);
        send_item(tra_pkg::CMD_STEP, 6'd0, 2'd0);
        send_item(tra_pkg::CMD_STEP, 6'd0, 2'd0);

        for (int p = 0; p < 7; p++)
        begin
            write_rule(rules[p]);
            if (p == 6)
                idle_on = 1'b0;
            run_generations(cmd_count + PHASE_CMDS);
        end

        drain_cells();
        repeat (RING_CELLS + 8) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.waiting() == 0)
            $display("ternary_ring_automaton test passed");
        else
            $display("ternary_ring_automaton test failed");
        $finish;
    end

endmodule
